### hdl/oul_pkg.sv
package oul_pkg;

   localparam int DEFAULT_CAPACITY = 16;
   localparam int VALUE_W          = 32;
   localparam int LEN_W            = 5;

   typedef enum logic [2:0] {
      REQ_RAW_APPEND = 3'd0,
      REQ_ADD_LAST   = 3'd1,
      REQ_ADD_FIRST  = 3'd2,
      REQ_ADD_BEFORE = 3'd3,
      REQ_ADD_AFTER  = 3'd4,
      REQ_REMOVE     = 3'd5,
      REQ_REVERSE    = 3'd6,
      REQ_DUMP       = 3'd7
   } req_code_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_IGNORED = 2'd1,
      ST_FULL    = 2'd2
   } status_code_type;

   typedef struct packed {
      req_code_type               req_type;
      logic signed [VALUE_W-1:0]  new_value;
      logic signed [VALUE_W-1:0]  anchor_value;
   } req_item_type;

   typedef struct packed {
      status_code_type            status;
      logic                       has_item;
      logic signed [VALUE_W-1:0]  item_value;
      logic [LEN_W-1:0]           list_length;
      logic                       last_of_run;
   } rsp_item_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_SEARCH,
      CELL_INS_TAIL,
      CELL_INS_FIRST,
      CELL_INS_BEFORE,
      CELL_INS_AFTER,
      CELL_DELETE,
      CELL_ROTATE
   } cell_op_type;

   typedef struct packed {
      cell_op_type                op;
      logic signed [VALUE_W-1:0]  key;
      logic signed [VALUE_W-1:0]  new_value;
   } cell_cmd_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_APPLY,
      S_REVERSE,
      S_DUMP
   } state_type;

endpackage

### hdl/oul_cell.sv
module oul_cell
   import oul_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY,
   parameter int INDEX    = 0,
   localparam int CNT_W   = $clog2(CAPACITY + 1),
   localparam int IDX_W   = $clog2(CAPACITY)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cell_cmd_type               cmd,
   input  logic [CNT_W-1:0]           count,
   input  logic [IDX_W-1:0]           lim,
   input  logic signed [VALUE_W-1:0]  front_value,
   input  logic signed [VALUE_W-1:0]  left_value,
   input  logic                       left_first,
   input  logic                       left_before,
   input  logic signed [VALUE_W-1:0]  right_value,
   input  logic                       key_seen_in,
   input  logic                       new_seen_in,
   output logic signed [VALUE_W-1:0]  value,
   output logic                       first,
   output logic                       trailing,
   output logic                       key_seen_out,
   output logic                       new_seen_out
);

   localparam logic [CNT_W-1:0] POS     = CNT_W'(INDEX);
   localparam logic [IDX_W-1:0] POS_IDX = IDX_W'(INDEX);

   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic                      first_ff, first_in;
   logic                      before_ff, before_in;
   logic                      held;
   logic                      hit_key;
   logic                      hit_new;

   assign held    = POS < count;
   assign hit_key = held && (value_ff == cmd.key);
   assign hit_new = held && (value_ff == cmd.new_value);

   assign key_seen_out = key_seen_in | hit_key;
   assign new_seen_out = new_seen_in | hit_new;

   always_comb begin
      value_in  = value_ff;
      first_in  = first_ff;
      before_in = before_ff;
      case (cmd.op)
         CELL_SEARCH: begin
            first_in  = hit_key && !key_seen_in;
            before_in = key_seen_in;
         end
         CELL_INS_TAIL: begin
            if (POS == count) value_in = cmd.new_value;
         end
         CELL_INS_FIRST: begin
            value_in = (INDEX == 0) ? cmd.new_value : left_value;
         end
         CELL_INS_BEFORE: begin
            if (first_ff) value_in = cmd.new_value;
            else if (before_ff) value_in = left_value;
         end
         CELL_INS_AFTER: begin
            if (left_first) value_in = cmd.new_value;
            else if (left_before) value_in = left_value;
         end
         CELL_DELETE: begin
            if (first_ff || before_ff) value_in = right_value;
         end
         CELL_ROTATE: begin
            // shift toward the front inside the window, wrap the front to its end
            if (POS_IDX < lim) value_in = right_value;
            else if (POS_IDX == lim) value_in = front_value;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         first_ff  <= 1'b0;
         before_ff <= 1'b0;
      end else begin
         first_ff  <= first_in;
         before_ff <= before_in;
      end
   end

   assign value    = value_ff;
   assign first    = first_ff;
   assign trailing = before_ff;

endmodule

### hdl/ordered_unique_list_engine.sv
// A non-dump request gives its one response from the apply state, after a search over all
// cells; the apply state shifts the chain and can take the next request unless the response
// is stalled or a reverse follows. Reverse then rotates shrinking windows of the chain and
// passes through idle, so the next request waits for it. A non-empty dump emits one element
// per cycle while the receiver does not stall, then returns to idle before the next request.
// Reset clears length and control state; stored values stay undefined until written.
module ordered_unique_list_engine
   import oul_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY,
   localparam int CNT_W   = $clog2(CAPACITY + 1),
   localparam int IDX_W   = $clog2(CAPACITY)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_item_type  req_item,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_item_type  rsp_item
);

   state_type                  state_ff, state_in;
   req_item_type               req_ff, req_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [IDX_W-1:0]           lim_ff, lim_in;
   logic [IDX_W-1:0]           dump_idx_ff, dump_idx_in;
   logic                       key_present_ff, key_present_in;
   logic                       new_present_ff, new_present_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_item_type               rsp_ff, rsp_in;

   cell_cmd_type               cmd;
   logic signed [VALUE_W-1:0]  cell_value [CAPACITY];
   logic                       cell_first [CAPACITY];
   logic                       cell_before [CAPACITY];
   logic                       key_seen [CAPACITY+1];
   logic                       new_seen [CAPACITY+1];

   logic                       rsp_free;
   logic                       req_fire;
   logic                       full;
   logic                       dump_multi;
   logic                       rev_multi;
   logic                       apply_open;
   logic                       dump_last;
   logic                       anchored;
   cell_op_type                apply_op;
   status_code_type            apply_status;
   logic [CNT_W-1:0]           apply_count;

   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign full       = count_ff == CNT_W'(CAPACITY);
   assign dump_multi = (req_ff.req_type == REQ_DUMP) && (count_ff != '0);
   assign rev_multi  = (req_ff.req_type == REQ_REVERSE) && (count_ff > CNT_W'(1));
   assign apply_open = (state_ff == S_APPLY) && rsp_free && !dump_multi && !rev_multi;
   assign req_stall  = !((state_ff == S_IDLE) || apply_open);
   assign req_fire   = req_valid && !req_stall;
   assign dump_last  = dump_idx_ff == lim_ff;
   assign anchored   = (req_item.req_type == REQ_ADD_BEFORE) ||
                       (req_item.req_type == REQ_ADD_AFTER);

   // decide the outcome of the held request from the search flags
   always_comb begin
      apply_op     = CELL_HOLD;
      apply_status = ST_DONE;
      apply_count  = count_ff;
      case (req_ff.req_type)
         REQ_RAW_APPEND: begin
            if (full) apply_status = ST_FULL;
            else apply_op = CELL_INS_TAIL;
         end
         REQ_ADD_LAST, REQ_ADD_FIRST: begin
            if (new_present_ff) apply_status = ST_IGNORED;
            else if (full) apply_status = ST_FULL;
            else if (req_ff.req_type == REQ_ADD_LAST) apply_op = CELL_INS_TAIL;
            else apply_op = CELL_INS_FIRST;
         end
         REQ_ADD_BEFORE, REQ_ADD_AFTER: begin
            if (!key_present_ff || new_present_ff) apply_status = ST_IGNORED;
            else if (full) apply_status = ST_FULL;
            else if (req_ff.req_type == REQ_ADD_BEFORE) apply_op = CELL_INS_BEFORE;
            else apply_op = CELL_INS_AFTER;
         end
         REQ_REMOVE: begin
            if (!new_present_ff) apply_status = ST_IGNORED;
            else apply_op = CELL_DELETE;
         end
         default: ;
      endcase
      if (apply_op == CELL_DELETE) apply_count = count_ff - 1'b1;
      else if (apply_op != CELL_HOLD) apply_count = count_ff + 1'b1;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_fire) state_in = S_SEARCH;
         S_SEARCH: state_in = S_APPLY;
         S_APPLY: begin
            if (dump_multi) state_in = S_DUMP;
            else if (rsp_free) begin
               if (rev_multi) state_in = S_REVERSE;
               else if (req_fire) state_in = S_SEARCH;
               else state_in = S_IDLE;
            end
         end
         S_REVERSE: if (lim_ff == IDX_W'(1)) state_in = S_IDLE;
         S_DUMP:    if (rsp_free && dump_last) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // datapath control and response
   always_comb begin
      req_in         = req_ff;
      count_in       = count_ff;
      lim_in         = lim_ff;
      dump_idx_in    = dump_idx_ff;
      key_present_in = key_present_ff;
      new_present_in = new_present_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      cmd.op         = CELL_HOLD;
      cmd.key        = req_ff.new_value;
      cmd.new_value  = req_ff.new_value;
      if (req_fire) begin
         req_in = req_item;
         if (anchored) req_in.anchor_value = req_item.anchor_value;
      end
      unique case (state_ff)
         S_IDLE: ;
         S_SEARCH: begin
            cmd.op = CELL_SEARCH;
            if (req_ff.req_type == REQ_ADD_BEFORE || req_ff.req_type == REQ_ADD_AFTER)
               cmd.key = req_ff.anchor_value;
            key_present_in = key_seen[CAPACITY];
            new_present_in = new_seen[CAPACITY];
         end
         S_APPLY: begin
            if (dump_multi) begin
               lim_in      = IDX_W'(count_ff - 1'b1);
               dump_idx_in = '0;
            end else if (rsp_free) begin
               cmd.op                  = apply_op;
               count_in                = apply_count;
               lim_in                  = IDX_W'(count_ff - 1'b1);
               rsp_valid_in            = 1'b1;
               rsp_in.status           = apply_status;
               rsp_in.has_item         = 1'b0;
               rsp_in.item_value       = '0;
               rsp_in.list_length      = LEN_W'(apply_count);
               rsp_in.last_of_run      = 1'b1;
            end
         end
         S_REVERSE: begin
            cmd.op = CELL_ROTATE;
            lim_in = lim_ff - 1'b1;
         end
         S_DUMP: begin
            if (rsp_free) begin
               cmd.op             = CELL_ROTATE;
               dump_idx_in        = dump_idx_ff + 1'b1;
               rsp_valid_in       = 1'b1;
               rsp_in.status      = ST_DONE;
               rsp_in.has_item    = 1'b1;
               rsp_in.item_value  = cell_value[0];
               rsp_in.list_length = LEN_W'(count_ff);
               rsp_in.last_of_run = dump_last;
            end
         end
         default: ;
      endcase
   end

   assign key_seen[0] = 1'b0;
   assign new_seen[0] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [VALUE_W-1:0] left_value;
      logic                      left_first;
      logic                      left_before;
      logic signed [VALUE_W-1:0] right_value;

      if (i == 0) begin : g_head
         assign left_value  = '0;
         assign left_first  = 1'b0;
         assign left_before = 1'b0;
      end else begin : g_body
         assign left_value  = cell_value[i-1];
         assign left_first  = cell_first[i-1];
         assign left_before = cell_before[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_value = '0;
      end else begin : g_inner
         assign right_value = cell_value[i+1];
      end

      oul_cell #(
         .CAPACITY (CAPACITY),
         .INDEX    (i)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .cmd          (cmd),
         .count        (count_ff),
         .lim          (lim_ff),
         .front_value  (cell_value[0]),
         .left_value   (left_value),
         .left_first   (left_first),
         .left_before  (left_before),
         .right_value  (right_value),
         .key_seen_in  (key_seen[i]),
         .new_seen_in  (new_seen[i]),
         .value        (cell_value[i]),
         .first        (cell_first[i]),
         .trailing     (cell_before[i]),
         .key_seen_out (key_seen[i+1]),
         .new_seen_out (new_seen[i+1])
      );
   end

   always_ff @(posedge clock) begin
      req_ff         <= req_in;
      lim_ff         <= lim_in;
      dump_idx_ff    <= dump_idx_in;
      key_present_ff <= key_present_in;
      new_present_ff <= new_present_in;
      rsp_ff         <= rsp_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("list length above capacity");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REVERSE || state_ff == S_DUMP || state_ff == S_SEARCH) |-> req_stall)
      else $error("request taken while the chain is busy");

   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(count_ff)) |-> ($past(state_ff) == S_APPLY))
      else $error("length changed outside the apply cycle");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DUMP && rsp_free && dump_last) |=> (state_ff == S_IDLE && rsp_valid_ff))
      else $error("dump did not finish after its last element");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH) |=> (state_ff == S_APPLY))
      else $error("search not followed by apply");

endmodule

### test/ordered_unique_list_engine_tb.sv
module ordered_unique_list_engine_tb;
   import oul_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAP          = DEFAULT_CAPACITY;
   localparam int RANDOM_ITEMS = 125;
   localparam int POOL_N       = 24;
   localparam int LONG_HOLD    = 300;
   localparam int IDLE_LIMIT   = 4000;
   localparam int TAIL_CYCLES  = 2 * CAP + 20;

   // Predicts the list contents and the responses each request causes.
   class list_scoreboard;
      logic signed [VALUE_W-1:0] held[$];
      rsp_item_type              due_rsp[$];
      int                        capacity;
      int                        mismatches;

      function new(int cap);
         capacity   = cap;
         mismatches = 0;
      endfunction

      function int find_first(logic signed [VALUE_W-1:0] v);
         foreach (held[i]) begin
            if (held[i] == v) return i;
         end
         return -1;
      endfunction

      function void push_rsp(status_code_type st, logic has, logic signed [VALUE_W-1:0] v,
                             logic last);
         rsp_item_type r;
         r.status      = st;
         r.has_item    = has;
         r.item_value  = v;
         r.list_length = LEN_W'(held.size());
         r.last_of_run = last;
         due_rsp.push_back(r);
      endfunction

      function void note_request(req_item_type rq);
         status_code_type           st;
         int                        at;
         int                        n;
         logic signed [VALUE_W-1:0] t;
         st = ST_DONE;
         case (rq.req_type)
            REQ_RAW_APPEND: begin
               if (held.size() >= capacity) st = ST_FULL;
               else held.push_back(rq.new_value);
            end
            REQ_ADD_LAST, REQ_ADD_FIRST: begin
               if (find_first(rq.new_value) >= 0) st = ST_IGNORED;
               else if (held.size() >= capacity) st = ST_FULL;
               else if (rq.req_type == REQ_ADD_LAST) held.push_back(rq.new_value);
               else held.push_front(rq.new_value);
            end
            REQ_ADD_BEFORE, REQ_ADD_AFTER: begin
               at = find_first(rq.anchor_value);
               if (at < 0 || find_first(rq.new_value) >= 0) st = ST_IGNORED;
               else if (held.size() >= capacity) st = ST_FULL;
               else held.insert(at + ((rq.req_type == REQ_ADD_AFTER) ? 1 : 0), rq.new_value);
            end
            REQ_REMOVE: begin
               at = find_first(rq.new_value);
               if (at < 0) st = ST_IGNORED;
               else held.delete(at);
            end
            REQ_REVERSE: begin
               n = held.size();
               for (int i = 0; i < n / 2; i++) begin
                  t               = held[i];
                  held[i]         = held[n - 1 - i];
                  held[n - 1 - i] = t;
               end
            end
            REQ_DUMP: begin
               if (held.size() == 0) push_rsp(ST_DONE, 1'b0, '0, 1'b1);
               foreach (held[i]) push_rsp(ST_DONE, 1'b1, held[i], i == held.size() - 1);
               return;
            end
            default: ;
         endcase
         push_rsp(st, 1'b0, '0, 1'b1);
      endfunction

      task report_mismatch(string what);
         $display("MISMATCH at %0t: %s", $time, what);
         mismatches++;
      endtask

      task check_response(rsp_item_type got);
         rsp_item_type want;
         if (due_rsp.size() == 0) begin
            report_mismatch("response with no request outstanding");
            return;
         end
         want = due_rsp.pop_front();
         if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
         if (got.has_item !== want.has_item)
            report_mismatch($sformatf("has_item %0b, want %0b", got.has_item, want.has_item));
         if (got.item_value !== want.item_value)
            report_mismatch($sformatf("item_value %0d, want %0d",
                                      got.item_value, want.item_value));
         if (got.list_length !== want.list_length)
            report_mismatch($sformatf("list_length %0d, want %0d",
                                      got.list_length, want.list_length));
         if (got.last_of_run !== want.last_of_run)
            report_mismatch($sformatf("last_of_run %0b, want %0b",
                                      got.last_of_run, want.last_of_run));
      endtask
   endclass

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_item_type req_item;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_item_type rsp_item;

   list_scoreboard            sb;
   logic signed [VALUE_W-1:0] value_pool[POOL_N];
   int                        reqs_accepted;
   int                        idle_cycles;
   int                        burst_left;

   ordered_unique_list_engine dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Both channels are sampled with the values they held just before the edge.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_item);
         if (req_valid && !req_stall) begin
            sb.note_request(req_item);
            reqs_accepted <= reqs_accepted + 1;
         end
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Receiver back-pressure: alternating patterns, plus one long hold-off.
   initial begin : rsp_stall_pattern
      int mode;
      int span;
      int phase;
      bit long_done;
      long_done = 1'b0;
      phase     = 0;
      rsp_stall = 1'b0;
      @(posedge clock);
      forever begin
         if (!long_done && reqs_accepted >= 70) begin
            long_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(5, 40);
            repeat (span) begin
               case (mode)
                  0:       rsp_stall <= 1'b0;
                  1:       rsp_stall <= ($urandom_range(0, 99) < 35);
                  default: rsp_stall <= (phase % 4 == 3);
               endcase
               phase++;
               @(posedge clock);
            end
         end
      end
   end

   task automatic send(input req_item_type it);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_item  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_op(input req_code_type op, input logic signed [VALUE_W-1:0] nv,
                          input logic signed [VALUE_W-1:0] av);
      req_item_type it;
      it.req_type     = op;
      it.new_value    = nv;
      it.anchor_value = av;
      send(it);
   endtask

   // Stop offering and wait until every predicted response has come back.
   task automatic drain();
      req_valid  <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (sb.due_rsp.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return value_pool[$urandom_range(0, POOL_N - 1)];
      if (r < 80 && sb.held.size() > 0) return sb.held[$urandom_range(0, sb.held.size() - 1)];
      return $urandom;
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_held_mostly();
      if ($urandom_range(0, 9) < 7 && sb.held.size() > 0)
         return sb.held[$urandom_range(0, sb.held.size() - 1)];
      return pick_value();
   endfunction

   // Growing segments favor inserts, shrinking segments favor removes.
   function automatic req_item_type random_request(bit grow);
      req_item_type rq;
      int           w;
      w = $urandom_range(0, 99);
      if (grow) begin
         if (w < 10)      rq.req_type = REQ_RAW_APPEND;
         else if (w < 35) rq.req_type = REQ_ADD_LAST;
         else if (w < 55) rq.req_type = REQ_ADD_FIRST;
         else if (w < 70) rq.req_type = REQ_ADD_BEFORE;
         else if (w < 85) rq.req_type = REQ_ADD_AFTER;
         else if (w < 92) rq.req_type = REQ_REMOVE;
         else if (w < 96) rq.req_type = REQ_REVERSE;
         else             rq.req_type = REQ_DUMP;
      end else begin
         if (w < 3)       rq.req_type = REQ_RAW_APPEND;
         else if (w < 13) rq.req_type = REQ_ADD_LAST;
         else if (w < 20) rq.req_type = REQ_ADD_FIRST;
         else if (w < 27) rq.req_type = REQ_ADD_BEFORE;
         else if (w < 34) rq.req_type = REQ_ADD_AFTER;
         else if (w < 80) rq.req_type = REQ_REMOVE;
         else if (w < 88) rq.req_type = REQ_REVERSE;
         else             rq.req_type = REQ_DUMP;
      end
      rq.new_value    = (rq.req_type == REQ_REMOVE) ? pick_held_mostly() : pick_value();
      rq.anchor_value = (rq.req_type == REQ_ADD_BEFORE || rq.req_type == REQ_ADD_AFTER) ?
                        pick_held_mostly() : pick_value();
      return rq;
   endfunction

   initial begin : stimulus
      logic signed [VALUE_W-1:0] vmin;
      logic signed [VALUE_W-1:0] vmax;
      bit                        grow;
      vmin          = {1'b1, {(VALUE_W - 1){1'b0}}};
      vmax          = {1'b0, {(VALUE_W - 1){1'b1}}};
      sb            = new(CAP);
      reqs_accepted = 0;
      burst_left    = 0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_item      = '0;
      value_pool[0] = vmin;
      value_pool[1] = vmax;
      value_pool[2] = '0;
      value_pool[3] = -1;
      for (int i = 4; i < POOL_N; i++) value_pool[i] = $urandom;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corner cases on an empty and a short list
      send_op(REQ_DUMP,       0,    0);
      send_op(REQ_REVERSE,    0,    0);
      send_op(REQ_REMOVE,     5,    0);
      send_op(REQ_ADD_LAST,   vmin, 0);
      send_op(REQ_REVERSE,    0,    0);
      send_op(REQ_ADD_BEFORE, 7,    9);
      send_op(REQ_ADD_AFTER,  vmin, vmin);
      send_op(REQ_ADD_FIRST,  vmax, 0);
      send_op(REQ_ADD_LAST,   vmin, 0);
      send_op(REQ_ADD_AFTER,  0,    vmax);
      send_op(REQ_ADD_BEFORE, -1,   vmin);
      send_op(REQ_REVERSE,    0,    0);
      send_op(REQ_DUMP,       0,    0);
      send_op(REQ_REMOVE,     vmax, 0);
      send_op(REQ_RAW_APPEND, 0,    0);
      send_op(REQ_REMOVE,     0,    0);
      send_op(REQ_DUMP,       0,    0);

      // fill to capacity, then try every insert on the full list
      drain();
      repeat (CAP - sb.held.size()) send_op(REQ_RAW_APPEND, $urandom, 0);
      send_op(REQ_RAW_APPEND, 3,    0);
      send_op(REQ_ADD_LAST,   11,   0);
      send_op(REQ_ADD_FIRST,  12,   0);
      send_op(REQ_ADD_BEFORE, 13,   vmin);
      send_op(REQ_ADD_AFTER,  14,   -1);
      send_op(REQ_DUMP,       0,    0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         grow = ((n / 20) % 2 == 0);
         if (n == 110) drain();
         send(random_request(grow));
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.due_rsp.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
hdl/oul_pkg.sv
hdl/oul_cell.sv
hdl/ordered_unique_list_engine.sv
test/ordered_unique_list_engine_tb.sv
